// File: rtl/core/abkf_pkg.sv
// ----------------------------------------------------------------------------
// abkf_pkg: shared types, constants and microcode for the angle/bias filter
// Payload structs, register map, control word layout and the sequencer program.
// ----------------------------------------------------------------------------
package abkf_pkg;

	// payload of one request on each channel
	typedef struct packed {
		logic signed [31:0] measured_angle;
		logic signed [31:0] gyro_rate;
		logic        [15:0] time_step;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] filtered_angle;
		logic signed [31:0] bias_estimate;
	} out_item_t;

	// register map, word index
	localparam logic [1:0] REG_PNA = 2'd0;
	localparam logic [1:0] REG_PNB = 2'd1;
	localparam logic [1:0] REG_MN  = 2'd2;

	localparam logic [30:0] PNA_RESET = 31'd16777;
	localparam logic [30:0] PNB_RESET = 31'd50332;
	localparam logic [30:0] MN_RESET  = 31'd503316;

	// gain limits, signed q1.30
	localparam logic signed [31:0] GAIN_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] GAIN_MIN = 32'sh8000_0000;

	// sequencer
	localparam int PC_W = 5;

	typedef enum logic [2:0] {
		SEQ_NEXT     = 3'd0,
		SEQ_WAIT_IN  = 3'd1,
		SEQ_WAIT_DIV = 3'd2,
		SEQ_EMIT     = 3'd3,
		SEQ_RESTART  = 3'd4
	} seq_t;

	typedef enum logic [2:0] {
		MA_T0  = 3'd0,
		MA_CBB = 3'd1,
		MA_PNB = 3'd2,
		MA_K0  = 3'd3,
		MA_K1  = 3'd4
	} mul_a_t;

	typedef enum logic [1:0] {
		MB_DT  = 2'd0,
		MB_T1  = 2'd1,
		MB_CAA = 2'd2,
		MB_CAB = 2'd3
	} mul_b_t;

	typedef enum logic [3:0] {
		A_ZERO = 4'd0,
		A_ANG  = 4'd1,
		A_BIA  = 4'd2,
		A_CAA  = 4'd3,
		A_CAB  = 4'd4,
		A_CBA  = 4'd5,
		A_CBB  = 4'd6,
		A_T0   = 4'd7,
		A_T1   = 4'd8,
		A_RATE = 4'd9,
		A_MEAS = 4'd10
	} alu_a_t;

	typedef enum logic [3:0] {
		B_ANG = 4'd0,
		B_BIA = 4'd1,
		B_CAB = 4'd2,
		B_CBA = 4'd3,
		B_T1  = 4'd4,
		B_PNA = 4'd5,
		B_MN  = 4'd6,
		B_P16 = 4'd7,
		B_P30 = 4'd8
	} alu_b_t;

	typedef enum logic [1:0] {
		SAT_NONE = 2'd0,
		SAT_DATA = 2'd1,
		SAT_WORD = 2'd2
	} sat_t;

	typedef enum logic [2:0] {
		D_T0  = 3'd0,
		D_T1  = 3'd1,
		D_ANG = 3'd2,
		D_BIA = 3'd3,
		D_CAA = 3'd4,
		D_CAB = 3'd5,
		D_CBA = 3'd6,
		D_CBB = 3'd7
	} dst_t;

	typedef struct packed {
		seq_t   seq;
		logic   mul_en;
		mul_a_t mul_a;
		mul_b_t mul_b;
		logic   alu_en;
		alu_a_t alu_a;
		alu_b_t alu_b;
		logic   neg;
		sat_t   sat;
		dst_t   dst;
		logic   div_start;
	} ucode_t;

	localparam ucode_t UW_NOP = '{
		seq: SEQ_NEXT, mul_en: 1'b0, mul_a: MA_T0, mul_b: MB_DT,
		alu_en: 1'b0, alu_a: A_ZERO, alu_b: B_ANG, neg: 1'b0,
		sat: SAT_NONE, dst: D_T0, div_start: 1'b0
	};

	// control word builders
	function automatic ucode_t uw_ctl(input seq_t s);
		ucode_t w;
		w = UW_NOP;
		w.seq = s;
		return w;
	endfunction

	function automatic ucode_t uw_mul(input mul_a_t a, input mul_b_t b);
		ucode_t w;
		w = UW_NOP;
		w.mul_en = 1'b1;
		w.mul_a = a;
		w.mul_b = b;
		return w;
	endfunction

	function automatic ucode_t uw_alu(input dst_t d, input alu_a_t a, input alu_b_t b,
			input logic n, input sat_t s);
		ucode_t w;
		w = UW_NOP;
		w.alu_en = 1'b1;
		w.dst = d;
		w.alu_a = a;
		w.alu_b = b;
		w.neg = n;
		w.sat = s;
		return w;
	endfunction

	function automatic ucode_t uw_alu_div(input dst_t d, input alu_a_t a, input alu_b_t b,
			input logic n, input sat_t s);
		ucode_t w;
		w = uw_alu(d, a, b, n, s);
		w.div_start = 1'b1;
		return w;
	endfunction

	// filter program: predict, gain, correct, emit
	function automatic ucode_t ucode_at(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			5'd0:  w = uw_ctl(SEQ_WAIT_IN);
			// rate minus bias, then angle advance
			5'd1:  w = uw_alu(D_T0, A_RATE, B_BIA, 1'b1, SAT_DATA);
			5'd2:  w = uw_mul(MA_T0, MB_DT);
			5'd3:  w = uw_alu(D_ANG, A_ANG, B_P16, 1'b0, SAT_DATA);
			// t11 = dt * cov_bb
			5'd4:  w = uw_mul(MA_CBB, MB_DT);
			5'd5:  w = uw_alu(D_T1, A_ZERO, B_P16, 1'b0, SAT_WORD);
			// t11 - cov_ab - cov_ba + angle noise
			5'd6:  w = uw_alu(D_T0, A_T1, B_CAB, 1'b1, SAT_NONE);
			5'd7:  w = uw_alu(D_T0, A_T0, B_CBA, 1'b1, SAT_NONE);
			5'd8:  w = uw_alu(D_T0, A_T0, B_PNA, 1'b0, SAT_NONE);
			5'd9:  w = uw_mul(MA_T0, MB_DT);
			5'd10: w = uw_alu(D_CAA, A_CAA, B_P16, 1'b0, SAT_WORD);
			5'd11: w = uw_alu(D_CAB, A_CAB, B_T1, 1'b1, SAT_WORD);
			5'd12: w = uw_alu(D_CBA, A_CBA, B_T1, 1'b1, SAT_WORD);
			5'd13: w = uw_mul(MA_PNB, MB_DT);
			5'd14: w = uw_alu(D_CBB, A_CBB, B_P16, 1'b0, SAT_WORD);
			// innovation variance, innovation, gain division
			5'd15: w = uw_alu(D_T0, A_CAA, B_MN, 1'b0, SAT_NONE);
			5'd16: w = uw_alu_div(D_T1, A_MEAS, B_ANG, 1'b1, SAT_WORD);
			5'd17: w = uw_ctl(SEQ_WAIT_DIV);
			// state correction
			5'd18: w = uw_mul(MA_K0, MB_T1);
			5'd19: w = uw_alu(D_ANG, A_ANG, B_P30, 1'b0, SAT_DATA);
			5'd20: w = uw_mul(MA_K1, MB_T1);
			5'd21: w = uw_alu(D_BIA, A_BIA, B_P30, 1'b0, SAT_DATA);
			// covariance shrink, old cov_aa and cov_ab read before overwrite
			5'd22: w = uw_mul(MA_K1, MB_CAA);
			5'd23: w = uw_alu(D_CBA, A_CBA, B_P30, 1'b1, SAT_WORD);
			5'd24: w = uw_mul(MA_K1, MB_CAB);
			5'd25: w = uw_alu(D_CBB, A_CBB, B_P30, 1'b1, SAT_WORD);
			5'd26: w = uw_mul(MA_K0, MB_CAB);
			5'd27: w = uw_alu(D_CAB, A_CAB, B_P30, 1'b1, SAT_WORD);
			5'd28: w = uw_mul(MA_K0, MB_CAA);
			5'd29: w = uw_alu(D_CAA, A_CAA, B_P30, 1'b1, SAT_WORD);
			5'd30: w = uw_ctl(SEQ_EMIT);
			default: w = uw_ctl(SEQ_RESTART);
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/abkf_div.sv
// ----------------------------------------------------------------------------
// abkf_div: two-lane radix-2 gain divider
// Computes (num * 2^30) / den for two numerators over one shared divisor,
// truncated toward zero and saturated to signed q1.30.
// ----------------------------------------------------------------------------
module abkf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [33:0] divisor,
	input  logic signed [31:0] numer0,
	input  logic signed [31:0] numer1,
	output logic               busy,
	output logic signed [31:0] gain0,
	output logic signed [31:0] gain1
);

	localparam int LANES = 2;

	logic              busy_q;
	logic [4:0]        cnt_q;
	logic              zero_q;
	logic [31:0]       dvs_q;
	logic [31:0]       rem_q [LANES];
	logic [31:0]       quo_q [LANES];
	logic              neg_q [LANES];
	logic              ovf_q [LANES];
	logic signed [31:0] numer [LANES];
	logic [31:0]       mag   [LANES];
	logic [31:0]       rem0  [LANES];
	logic [32:0]       trial [LANES];
	logic              ge    [LANES];
	logic signed [31:0] gain [LANES];

	assign numer[0] = numer0;
	assign numer[1] = numer1;

	// operand magnitude, initial partial remainder and one restoring step
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			mag[i]   = numer[i][31] ? (~numer[i] + 32'd1) : numer[i];
			rem0[i]  = {2'b00, mag[i][31:2]};
			trial[i] = {rem_q[i], quo_q[i][31]};
			ge[i]    = trial[i] >= {1'b0, dvs_q};
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	// per-lane remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= divisor[33] || (divisor == '0);
			dvs_q  <= divisor[31:0];
			for (int i = 0; i < LANES; i++) begin
				neg_q[i] <= numer[i][31];
				ovf_q[i] <= rem0[i] >= divisor[31:0];
				rem_q[i] <= rem0[i];
				quo_q[i] <= {mag[i][1:0], 30'd0};
			end
		end else if (busy_q) begin
			for (int i = 0; i < LANES; i++) begin
				rem_q[i] <= ge[i] ? 32'(trial[i] - {1'b0, dvs_q}) : trial[i][31:0];
				quo_q[i] <= {quo_q[i][30:0], ge[i]};
			end
		end
	end

	// sign and saturation of the quotient
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (zero_q) begin
				gain[i] = '0;
			end else if (!neg_q[i]) begin
				gain[i] = (ovf_q[i] || quo_q[i][31]) ? abkf_pkg::GAIN_MAX : quo_q[i];
			end else if (ovf_q[i] || (quo_q[i] > 32'h8000_0000)) begin
				gain[i] = abkf_pkg::GAIN_MIN;
			end else begin
				gain[i] = ~quo_q[i] + 32'd1;
			end
		end
	end

	assign busy  = busy_q;
	assign gain0 = gain[0];
	assign gain1 = gain[1];

endmodule

// File: rtl/core/angle_bias_kalman_filter_top.sv
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_top: two-state angle / gyro-bias kalman filter
// Microcoded datapath with one shared multiplier, one saturating adder and an
// iterative gain divider, fusing accelerometer angle and gyro rate per sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one sample request:
//   measured angle and gyro rate in signed q16.16, time step in q0.16 seconds.
//   Output channel (out_valid / out_stall / out_data) returns one request per
//   sample with the filtered angle and the bias estimate, both saturated q16.16.
//   The apb port sets the two process noise terms and the measurement noise
//   (q8.24) at byte addresses 0, 4 and 8; write them only while idle.
// Sequencing:
//   Samples are handled one at a time: a new sample is taken only at the top
//   of the program, once the previous result has left it. The sequencer runs
//   all products through one multiplier, and the radix-2 divider forms both
//   gains in parallel while the program waits for it.
// Reset and flow control:
//   Reset clears the angle, bias and covariance and restores the default noise
//   registers. A stalled result stays in the output register; the next sample
//   is still accepted and computed, and waits at the end of its program until
//   the output register frees up.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter_top #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// sample requests
	input  logic                in_valid,
	output logic                in_stall,
	input  abkf_pkg::in_item_t  in_data,
	// result requests
	output logic                out_valid,
	input  logic                out_stall,
	output abkf_pkg::out_item_t out_data
);

	// multiplier a port, alu width, multiplier b port, product width
	localparam int AMW = (DATA_WIDTH > 35) ? DATA_WIDTH : 35;
	localparam int AW  = AMW + 2;
	localparam int BW  = 33;
	localparam int PW  = AMW + BW;

	localparam logic signed [AW-1:0] SAT_D_MAX = {{(AW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [AW-1:0] SAT_D_MIN = {{(AW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [AW-1:0] SAT_W_MAX = {{(AW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [AW-1:0] SAT_W_MIN = {{(AW-31){1'b1}}, {31{1'b0}}};

	// sequencer step
	localparam logic [abkf_pkg::PC_W-1:0] PC_ONE = {{(abkf_pkg::PC_W-1){1'b0}}, 1'b1};

	// configuration registers
	logic [30:0] pna_q;
	logic [30:0] pnb_q;
	logic [30:0] mn_q;

	// sequencer
	logic [abkf_pkg::PC_W-1:0] pc_q;
	abkf_pkg::ucode_t          uw;

	// sample and state
	logic signed [31:0]           meas_q;
	logic signed [31:0]           rate_q;
	logic        [15:0]           dt_q;
	logic signed [DATA_WIDTH-1:0] ang_q;
	logic signed [DATA_WIDTH-1:0] bia_q;
	logic signed [31:0]           caa_q;
	logic signed [31:0]           cab_q;
	logic signed [31:0]           cba_q;
	logic signed [31:0]           cbb_q;
	logic signed [AMW-1:0]        t0_q;
	logic signed [31:0]           t1_q;
	logic signed [PW-1:0]         prod_q;

	// datapath nets
	logic signed [AMW-1:0] mul_a;
	logic signed [BW-1:0]  mul_b;
	logic signed [AW-1:0]  alu_a;
	logic signed [AW-1:0]  alu_b;
	logic                  rnd;
	logic signed [AW-1:0]  sum;
	logic signed [AW-1:0]  res;

	// divider
	logic               div_busy;
	logic signed [31:0] k0;
	logic signed [31:0] k1;

	// handshakes
	logic                cfg_we;
	logic                in_acc;
	logic                emit;
	logic                out_valid_q;
	abkf_pkg::out_item_t out_q;
	logic signed [AW-1:0] ang_ext;
	logic signed [AW-1:0] bia_ext;
	logic signed [AW-1:0] ang_sat;
	logic signed [AW-1:0] bia_sat;

	assign uw = abkf_pkg::ucode_at(pc_q);

	// apb register file, zero wait states
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pna_q <= abkf_pkg::PNA_RESET;
			pnb_q <= abkf_pkg::PNB_RESET;
			mn_q  <= abkf_pkg::MN_RESET;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				abkf_pkg::REG_PNA: pna_q <= pwdata[30:0];
				abkf_pkg::REG_PNB: pnb_q <= pwdata[30:0];
				abkf_pkg::REG_MN:  mn_q  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			abkf_pkg::REG_PNA: prdata = {1'b0, pna_q};
			abkf_pkg::REG_PNB: prdata = {1'b0, pnb_q};
			abkf_pkg::REG_MN:  prdata = {1'b0, mn_q};
			default:           prdata = '0;
		endcase
	end

	// input handshake, open only at the top of the program
	assign in_stall = (uw.seq != abkf_pkg::SEQ_WAIT_IN);
	assign in_acc   = in_valid && !in_stall;

	// result leaves the program once the output register is free
	assign emit = (uw.seq == abkf_pkg::SEQ_EMIT) && (!out_valid_q || !out_stall);

	// step counter with conditional holds and return to start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else begin
			unique case (uw.seq)
				abkf_pkg::SEQ_NEXT:     pc_q <= pc_q + PC_ONE;
				abkf_pkg::SEQ_WAIT_IN:  if (in_acc) pc_q <= pc_q + PC_ONE;
				abkf_pkg::SEQ_WAIT_DIV: if (!div_busy) pc_q <= pc_q + PC_ONE;
				abkf_pkg::SEQ_EMIT:     if (emit) pc_q <= '0;
				abkf_pkg::SEQ_RESTART:  pc_q <= '0;
				default:                pc_q <= '0;
			endcase
		end
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			meas_q <= in_data.measured_angle;
			rate_q <= in_data.gyro_rate;
			dt_q   <= in_data.time_step;
		end
	end

	// multiplier operand select
	always_comb begin
		case (uw.mul_a)
			abkf_pkg::MA_T0:  mul_a = t0_q;
			abkf_pkg::MA_CBB: mul_a = AMW'(cbb_q);
			abkf_pkg::MA_PNB: mul_a = AMW'({1'b0, pnb_q});
			abkf_pkg::MA_K0:  mul_a = AMW'(k0);
			abkf_pkg::MA_K1:  mul_a = AMW'(k1);
			default:          mul_a = '0;
		endcase
		case (uw.mul_b)
			abkf_pkg::MB_DT:  mul_b = BW'({1'b0, dt_q});
			abkf_pkg::MB_T1:  mul_b = BW'(t1_q);
			abkf_pkg::MB_CAA: mul_b = BW'(caa_q);
			abkf_pkg::MB_CAB: mul_b = BW'(cab_q);
			default:          mul_b = '0;
		endcase
	end

	// shared multiplier, product registered
	always_ff @(posedge clk) begin
		if (uw.mul_en) begin
			prod_q <= PW'(mul_a) * PW'(mul_b);
		end
	end

	// adder operand select; product taps carry their rounding bit
	always_comb begin
		rnd = 1'b0;
		case (uw.alu_a)
			abkf_pkg::A_ZERO: alu_a = '0;
			abkf_pkg::A_ANG:  alu_a = AW'(ang_q);
			abkf_pkg::A_BIA:  alu_a = AW'(bia_q);
			abkf_pkg::A_CAA:  alu_a = AW'(caa_q);
			abkf_pkg::A_CAB:  alu_a = AW'(cab_q);
			abkf_pkg::A_CBA:  alu_a = AW'(cba_q);
			abkf_pkg::A_CBB:  alu_a = AW'(cbb_q);
			abkf_pkg::A_T0:   alu_a = AW'(t0_q);
			abkf_pkg::A_T1:   alu_a = AW'(t1_q);
			abkf_pkg::A_RATE: alu_a = AW'(rate_q);
			abkf_pkg::A_MEAS: alu_a = AW'(meas_q);
			default:          alu_a = '0;
		endcase
		case (uw.alu_b)
			abkf_pkg::B_ANG: alu_b = AW'(ang_q);
			abkf_pkg::B_BIA: alu_b = AW'(bia_q);
			abkf_pkg::B_CAB: alu_b = AW'(cab_q);
			abkf_pkg::B_CBA: alu_b = AW'(cba_q);
			abkf_pkg::B_T1:  alu_b = AW'(t1_q);
			abkf_pkg::B_PNA: alu_b = AW'({1'b0, pna_q});
			abkf_pkg::B_MN:  alu_b = AW'({1'b0, mn_q});
			abkf_pkg::B_P16: begin
				alu_b = AW'(prod_q >>> 16);
				rnd   = prod_q[15];
			end
			abkf_pkg::B_P30: begin
				alu_b = AW'(prod_q >>> 30);
				rnd   = prod_q[29];
			end
			default:         alu_b = '0;
		endcase
	end

	// add or subtract with rounding folded into the carry, then saturate as selected
	always_comb begin
		if (uw.neg) begin
			sum = alu_a + ~alu_b + AW'(!rnd);
		end else begin
			sum = alu_a + alu_b + AW'(rnd);
		end
		case (uw.sat)
			abkf_pkg::SAT_DATA:
				res = (sum > SAT_D_MAX) ? SAT_D_MAX : ((sum < SAT_D_MIN) ? SAT_D_MIN : sum);
			abkf_pkg::SAT_WORD:
				res = (sum > SAT_W_MAX) ? SAT_W_MAX : ((sum < SAT_W_MIN) ? SAT_W_MIN : sum);
			default:
				res = sum;
		endcase
	end

	// filter state, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q <= '0;
			bia_q <= '0;
			caa_q <= '0;
			cab_q <= '0;
			cba_q <= '0;
			cbb_q <= '0;
		end else if (uw.alu_en) begin
			case (uw.dst)
				abkf_pkg::D_ANG: ang_q <= res[DATA_WIDTH-1:0];
				abkf_pkg::D_BIA: bia_q <= res[DATA_WIDTH-1:0];
				abkf_pkg::D_CAA: caa_q <= res[31:0];
				abkf_pkg::D_CAB: cab_q <= res[31:0];
				abkf_pkg::D_CBA: cba_q <= res[31:0];
				abkf_pkg::D_CBB: cbb_q <= res[31:0];
				default: ;
			endcase
		end
	end

	// scratch registers
	always_ff @(posedge clk) begin
		if (uw.alu_en) begin
			case (uw.dst)
				abkf_pkg::D_T0: t0_q <= res[AMW-1:0];
				abkf_pkg::D_T1: t1_q <= res[31:0];
				default: ;
			endcase
		end
	end

	// kalman gains from cov_aa and cov_ba over the innovation variance
	abkf_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (uw.div_start),
		.divisor (t0_q[33:0]),
		.numer0  (caa_q),
		.numer1  (cba_q),
		.busy    (div_busy),
		.gain0   (k0),
		.gain1   (k1)
	);

	// result clamp to the 32-bit output format
	always_comb begin
		ang_ext = AW'(ang_q);
		bia_ext = AW'(bia_q);
		ang_sat = (ang_ext > SAT_W_MAX) ? SAT_W_MAX :
			((ang_ext < SAT_W_MIN) ? SAT_W_MIN : ang_ext);
		bia_sat = (bia_ext > SAT_W_MAX) ? SAT_W_MAX :
			((bia_ext < SAT_W_MIN) ? SAT_W_MIN : bia_ext);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.filtered_angle <= ang_sat[31:0];
			out_q.bias_estimate  <= bia_sat[31:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the angle / gyro-bias kalman filter
// Sends sample requests in random bursts against a sink that stalls on its own
// pattern, predicts each result with a bit-exact fixed-point filter and checks
// it field by field. The noise registers are reprogrammed and read back over
// the apb port between phases, covering their extremes and random values.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 10;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 131;
	localparam int DRAIN_CYCLES    = 80;
	localparam int MAX_PRINTED     = 100;
	localparam int N_DIRECTED      = 18;

	localparam longint W_MAX = 64'sd2147483647;
	localparam longint W_MIN = -W_MAX - 1;
	localparam longint ANGLE_SPAN = 64'sd11796480;  // 180 degrees in q16.16

	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic [30:0]        NOISE_MAX = 31'h7fff_ffff;
	localparam logic [1:0]         REG_UNUSED = 2'd3;

	typedef enum int {
		SINK_FREE,
		SINK_HOLD,
		SINK_JITTER
	} sink_mode_t;

	// one row of the directed table
	typedef struct packed {
		logic signed [31:0] meas;
		logic signed [31:0] rate;
		logic        [15:0] dt;
		logic               typed;
		logic signed [31:0] want_angle;
		logic signed [31:0] want_bias;
	} step_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	abkf_pkg::in_item_t  in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	abkf_pkg::out_item_t out_data;

	// typed result that travels with a directed request
	logic        fixed_valid = 1'b0;
	abkf_pkg::out_item_t fixed_result = '0;

	// predictor copy of the noise registers, estimate and covariance
	longint q_angle, q_bias, r_meas;
	longint x_angle, x_bias;
	longint p_aa, p_ab, p_ba, p_bb;

	abkf_pkg::out_item_t filter_results[$];
	int         mismatches = 0;
	int         sent_count = 0;
	int         done_count = 0;
	int         burst_left = 0;
	longint     cycles = 0;
	longint     walk_angle = 0;
	sink_mode_t sink_mode = SINK_FREE;
	int         sink_left = 0;

	// right after reset the covariance is zero, so the gains are zero and a
	// zero time step leaves everything at zero
	step_row_t directed_rows [N_DIRECTED] = '{
		'{32'sd0, 32'sd0, 16'd0, 1'b1, 32'sd0, 32'sd0},
		'{S32_MAX, S32_MIN, 16'd0, 1'b1, 32'sd0, 32'sd0},
		'{S32_MIN, S32_MAX, 16'd0, 1'b1, 32'sd0, 32'sd0},
		'{-32'sd1, -32'sd1, 16'd0, 1'b1, 32'sd0, 32'sd0},
		'{32'sh5555_5555, 32'shaaaa_aaaa, 16'd0, 1'b1, 32'sd0, 32'sd0},
		'{32'shaaaa_aaaa, 32'sh5555_5555, 16'd0, 1'b1, 32'sd0, 32'sd0},
		'{32'sd0, 32'sd0, 16'd1, 1'b0, 32'sd0, 32'sd0},
		'{32'sd655360, 32'sd0, 16'd65, 1'b0, 32'sd0, 32'sd0},
		'{32'sd655360, 32'sd65536, 16'd65, 1'b0, 32'sd0, 32'sd0},
		'{32'sd0, S32_MAX, 16'hffff, 1'b0, 32'sd0, 32'sd0},
		'{32'sd0, S32_MAX, 16'hffff, 1'b0, 32'sd0, 32'sd0},
		'{S32_MIN, S32_MIN, 16'hffff, 1'b0, 32'sd0, 32'sd0},
		'{S32_MIN, S32_MAX, 16'h8000, 1'b0, 32'sd0, 32'sd0},
		'{S32_MAX, S32_MIN, 16'hffff, 1'b0, 32'sd0, 32'sd0},
		'{32'sd0, 32'sd0, 16'd0, 1'b0, 32'sd0, 32'sd0},
		'{-32'sd655360, -32'sd65536, 16'h5555, 1'b0, 32'sd0, 32'sd0},
		'{32'sd655360, 32'sd0, 16'haaaa, 1'b0, 32'sd0, 32'sd0},
		'{32'sd0, 32'sd0, 16'd65, 1'b0, 32'sd0, 32'sd0}
	};

	angle_bias_kalman_filter_top #(
		.DATA_WIDTH(32)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// fixed-point helpers
	function automatic longint sat32(input longint v);
		if (v > W_MAX) return W_MAX;
		if (v < W_MIN) return W_MIN;
		return v;
	endfunction

	// round to nearest, halves toward +inf
	function automatic longint round_shift(input longint v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// q1.30 gain, quotient truncated toward zero
	function automatic longint gain_q30(input longint c, input longint s);
		if (s <= 0) return 0;
		return sat32((c * 64'sd1073741824) / s);
	endfunction

	// one predict / correct step of the filter
	function automatic abkf_pkg::out_item_t kalman_step(input abkf_pkg::in_item_t smp);
		longint meas, rate, dt, d, t11, s, k0, k1, y, old_aa, old_ab;
		abkf_pkg::out_item_t r;
		meas = longint'(smp.measured_angle);
		rate = longint'(smp.gyro_rate);
		dt = longint'(smp.time_step);

		// predict
		d = sat32(rate - x_bias);
		x_angle = sat32(x_angle + round_shift(dt * d, 16));
		t11 = round_shift(dt * p_bb, 16);
		p_aa = sat32(p_aa + round_shift(dt * (t11 - p_ab - p_ba + q_angle), 16));
		p_ab = sat32(p_ab - t11);
		p_ba = sat32(p_ba - t11);
		p_bb = sat32(p_bb + round_shift(q_bias * dt, 16));

		// gains and innovation
		s = p_aa + r_meas;
		k0 = gain_q30(p_aa, s);
		k1 = gain_q30(p_ba, s);
		y = sat32(meas - x_angle);

		// correct state, then shrink covariance from the predicted terms
		x_angle = sat32(x_angle + round_shift(k0 * y, 30));
		x_bias = sat32(x_bias + round_shift(k1 * y, 30));
		old_aa = p_aa;
		old_ab = p_ab;
		p_aa = sat32(p_aa - round_shift(k0 * old_aa, 30));
		p_ab = sat32(p_ab - round_shift(k0 * old_ab, 30));
		p_ba = sat32(p_ba - round_shift(k1 * old_aa, 30));
		p_bb = sat32(p_bb - round_shift(k1 * old_ab, 30));

		r.filtered_angle = 32'(x_angle);
		r.bias_estimate = 32'(x_bias);
		return r;
	endfunction

	function automatic longint noise_reg(input logic [1:0] idx);
		case (idx)
			abkf_pkg::REG_PNA: return q_angle;
			abkf_pkg::REG_PNB: return q_bias;
			default: return r_meas;
		endcase
	endfunction

	function automatic logic [30:0] random_noise();
		case ($urandom_range(0, 3))
			0: return 31'd0;
			1: return NOISE_MAX;
			2: return 31'($urandom_range(1, 1 << 22));
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic logic signed [31:0] corner32();
		case ($urandom_range(0, 3))
			0: return S32_MAX;
			1: return S32_MIN;
			2: return 32'sd0;
			default: return 32'($urandom);
		endcase
	endfunction

	// mostly plausible imu samples around a drifting angle, plus noise and corners
	function automatic abkf_pkg::in_item_t random_sample();
		abkf_pkg::in_item_t smp;
		longint rate, dt, jitter;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			rate = longint'($urandom_range(0, 65536000)) - 64'sd32768000;
			dt = longint'($urandom_range(1, 2000));
			walk_angle = walk_angle + ((rate * dt) >>> 16);
			if (walk_angle > ANGLE_SPAN) walk_angle = ANGLE_SPAN;
			if (walk_angle < -ANGLE_SPAN) walk_angle = -ANGLE_SPAN;
			jitter = longint'($urandom_range(0, 393216)) - 64'sd196608;
			smp.measured_angle = 32'(walk_angle + jitter);
			smp.gyro_rate = 32'(rate);
			smp.time_step = 16'(dt);
		end else if (pick < 90) begin
			smp = {$urandom, $urandom, 16'($urandom)};
		end else begin
			smp.measured_angle = corner32();
			smp.gyro_rate = corner32();
			case ($urandom_range(0, 3))
				0: smp.time_step = 16'd0;
				1: smp.time_step = 16'd1;
				2: smp.time_step = 16'hffff;
				default: smp.time_step = 16'($urandom);
			endcase
		end
		return smp;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTED) $display("tb mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// apb write, setup then access; bus stays selected until released
	task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			abkf_pkg::REG_PNA: q_angle = longint'(data[30:0]);
			abkf_pkg::REG_PNB: q_bias = longint'(data[30:0]);
			abkf_pkg::REG_MN:  r_meas = longint'(data[30:0]);
			default: ;
		endcase
	endtask

	task automatic apb_release();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// read back the three noise registers
	task automatic check_noise_regs();
		logic [31:0] want;
		for (int i = 0; i < 3; i++) begin
			want = {1'b0, 31'(noise_reg(2'(i)))};
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= {2'(i), 2'b00};
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready) @(posedge clk);
			if (prdata !== want)
				report_mismatch($sformatf("register %0d read %h want %h", i, prdata, want));
		end
		apb_release();
	endtask

	// bit 31 of the write data is random and must be dropped
	task automatic program_noise(input logic [30:0] na, input logic [30:0] nb,
			input logic [30:0] nm);
		apb_write(abkf_pkg::REG_PNA, {1'($urandom_range(0, 1)), na});
		apb_write(REG_UNUSED, $urandom);
		apb_write(abkf_pkg::REG_PNB, {1'($urandom_range(0, 1)), nb});
		apb_write(abkf_pkg::REG_MN, {1'($urandom_range(0, 1)), nm});
		check_noise_regs();
	endtask

	// sender: bursts of random length with random gaps between them
	task automatic send_sample(input abkf_pkg::in_item_t smp, input logic typed,
			input abkf_pkg::out_item_t res);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 60);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		in_valid <= 1'b1;
		in_data <= smp;
		fixed_valid <= typed;
		fixed_result <= res;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_count++;
		burst_left--;
	endtask

	// predict on every accepted sample request
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin : sample_accept
			abkf_pkg::out_item_t predicted;
			predicted = kalman_step(in_data);
			filter_results.push_back(fixed_valid ? fixed_result : predicted);
		end
	end

	// result sink stall pattern: free runs, held stalls and jitter
	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 2));
			sink_left = $urandom_range(1, (sink_mode == SINK_HOLD) ? 60 : 150);
		end
		sink_left--;
		case (sink_mode)
			SINK_FREE: out_stall <= 1'b0;
			SINK_HOLD: out_stall <= 1'b1;
			default:   out_stall <= 1'($urandom_range(0, 1));
		endcase
	end

	// compare each accepted result request with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin : result_check
			abkf_pkg::out_item_t want;
			done_count++;
			if (filter_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", out_data));
			end else begin
				want = filter_results.pop_front();
				if (out_data.filtered_angle !== want.filtered_angle)
					report_mismatch($sformatf("filtered_angle got %h want %h",
						out_data.filtered_angle, want.filtered_angle));
				if (out_data.bias_estimate !== want.bias_estimate)
					report_mismatch($sformatf("bias_estimate got %h want %h",
						out_data.bias_estimate, want.bias_estimate));
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		logic [30:0] na, nb, nm;
		step_row_t row;
		abkf_pkg::out_item_t res;
		int count;
		q_angle = longint'(abkf_pkg::PNA_RESET);
		q_bias = longint'(abkf_pkg::PNB_RESET);
		r_meas = longint'(abkf_pkg::MN_RESET);
		x_angle = 0;
		x_bias = 0;
		p_aa = 0;
		p_ab = 0;
		p_ba = 0;
		p_bb = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_noise_regs();

		for (int ph = 0; ph < PHASES; ph++) begin
			// noise settings: extremes first, then default, then random
			if (ph > 0) begin
				case (ph)
					1: begin
						na = NOISE_MAX; nb = NOISE_MAX; nm = NOISE_MAX;
					end
					2: begin
						na = 31'd0; nb = 31'd0; nm = 31'd1;
					end
					3: begin
						na = NOISE_MAX; nb = NOISE_MAX; nm = 31'd1;
					end
					4: begin
						na = abkf_pkg::PNA_RESET;
						nb = abkf_pkg::PNB_RESET;
						nm = abkf_pkg::MN_RESET;
					end
					default: begin
						na = random_noise();
						nb = random_noise();
						nm = random_noise();
						if (nm == 31'd0) nm = 31'd1;
					end
				endcase
				program_noise(na, nb, nm);
			end

			count = ITEMS_PER_PHASE;
			if (ph == 0) begin
				for (int i = 0; i < N_DIRECTED; i++) begin
					row = directed_rows[i];
					res.filtered_angle = row.want_angle;
					res.bias_estimate = row.want_bias;
					send_sample({row.meas, row.rate, row.dt}, row.typed, res);
				end
				count = ITEMS_PER_PHASE - N_DIRECTED;
			end
			for (int i = 0; i < count; i++)
				send_sample(random_sample(), 1'b0, '0);

			// drain before touching the registers again
			in_valid <= 1'b0;
			burst_left = 0;
			while (done_count < sent_count) @(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (filter_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", filter_results.size()));
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
